[hw/rtl/ndt_pkg.sv]
// ----------------------------------------------------------------------------
// ndt_pkg
// Shared types and constants of the network device table.
// ----------------------------------------------------------------------------
package ndt_pkg;

	// table geometry
	localparam int MaxDevices   = 16;
	localparam int MaxEndpoints = 8;
	localparam int DevIdxW      = 4;   // slot index
	localparam int EpIdxW       = 3;   // endpoint position
	localparam int CountW       = 5;   // device count, 0..MaxDevices
	localparam int EpCntW       = 4;   // endpoint count, 0..MaxEndpoints
	localparam int EpAddrW      = DevIdxW + EpIdxW;
	localparam int CopyPtrW     = EpAddrW + 1;
	localparam int EpWordW      = 12;  // {kind, value}

	// operation codes
	localparam logic [2:0] OP_JOIN     = 3'd0;
	localparam logic [2:0] OP_IDX_LOOK = 3'd1;
	localparam logic [2:0] OP_TYPE_LOOK = 3'd2;
	localparam logic [2:0] OP_EP_WRITE = 3'd3;
	localparam logic [2:0] OP_EP_LOOK  = 3'd4;
	localparam logic [2:0] OP_REMOVE   = 3'd5;

	// device kinds
	localparam logic [1:0] KIND_UNDEF = 2'd0;
	localparam logic [1:0] KIND_COORD = 2'd1;
	localparam logic [1:0] KIND_UPPER = 2'd2;
	localparam logic [1:0] KIND_LOWER = 2'd3;

	// register indexes
	localparam logic [2:0] REG_JOIN_CMD   = 3'd0;
	localparam logic [2:0] REG_COORD_ID   = 3'd1;
	localparam logic [2:0] REG_COORD_EP   = 3'd2;
	localparam logic [2:0] REG_UPPER_CODE = 3'd3;
	localparam logic [2:0] REG_LOWER_CODE = 3'd4;
	localparam logic [2:0] REG_JOIN_KIND  = 3'd5;

	typedef struct packed {
		logic [7:0]  join_cmd;
		logic [15:0] coord_id;
		logic [7:0]  coord_ep;
		logic [7:0]  upper_code;
		logic [7:0]  lower_code;
		logic [3:0]  join_kind;
	} ndt_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic idx_inc;
		logic hit;
		logic ins_coord;
		logic ins_new;
		logic full_rej;
		logic ep_write;
		logic remove;
		logic ep_rd;
		logic ep_chk;
		logic copy_step;
		logic out_load;
	} ndt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic cmd_match;
		logic count_zero;
		logic table_full;
		logic idx_end;
		logic id_match;
		logic ep_end;
		logic ep_match;
		logic remove_ok;
		logic copy_done;
		logic out_free;
	} ndt_sts_t;

endpackage

[hw/rtl/ndt_ram.sv]
// ----------------------------------------------------------------------------
// ndt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ndt_datapath.sv]
// ----------------------------------------------------------------------------
// ndt_datapath
// Device registers, endpoint RAM, search pointers and result/output register.
// ----------------------------------------------------------------------------
module ndt_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ndt_pkg::ndt_cfg_t cfg,
	input  logic [55:0]      s_tdata,
	input  ndt_pkg::ndt_cmd_t cmd,
	output ndt_pkg::ndt_sts_t sts,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [23:0]      m_tdata,
	output logic [ndt_pkg::CountW-1:0] dev_count
);

	localparam int DW = ndt_pkg::DevIdxW;
	localparam int CW = ndt_pkg::CountW;
	localparam int PW = ndt_pkg::CopyPtrW;

	// captured input word
	logic [2:0]  op_q;
	logic [7:0]  cmd_id_q;
	logic [15:0] nid_q;
	logic [7:0]  rep_q;
	logic [7:0]  epv_q;
	logic [3:0]  epk_q;
	logic [DW-1:0] slot_q;
	logic [ndt_pkg::EpIdxW-1:0] eps_q;

	// device table
	logic [15:0] ids_q   [ndt_pkg::MaxDevices];
	logic [1:0]  kinds_q [ndt_pkg::MaxDevices];
	logic [ndt_pkg::EpCntW-1:0] epcnt_q [ndt_pkg::MaxDevices];
	logic [CW-1:0] count_q;

	// pointers and results
	logic [CW-1:0] idx_q;
	logic [ndt_pkg::EpCntW-1:0] j_q;
	logic [PW-1:0] rd_q;
	logic [PW-1:0] end_q;
	logic          pend_s1;
	logic [PW-1:0] wa_s1;
	logic          found_q;
	logic [DW-1:0] fidx_q;
	logic [1:0]    fkind_q;
	logic [7:0]    fep_q;
	logic          rej_q;
	logic          out_valid_q;
	logic [23:0]   out_data_q;

	// endpoint RAM signals
	logic          ram_we;
	logic [ndt_pkg::EpAddrW-1:0] ram_waddr;
	logic [ndt_pkg::EpWordW-1:0] ram_wdata;
	logic [ndt_pkg::EpAddrW-1:0] ram_raddr;
	logic [ndt_pkg::EpWordW-1:0] ram_rdata;

	logic [1:0]    new_kind;
	logic          epw_ok;
	logic [DW-1:0] cnt_idx;

	ndt_ram #(.WIDTH(ndt_pkg::EpWordW), .DEPTH(ndt_pkg::MaxDevices * ndt_pkg::MaxEndpoints))
	u_ep_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cnt_idx = count_q[DW-1:0];
	assign epw_ok  = ({1'b0, slot_q} < count_q);

	// kind of a newly joined device
	always_comb begin
		if (rep_q == cfg.upper_code) begin
			new_kind = ndt_pkg::KIND_UPPER;
		end else if (rep_q == cfg.lower_code) begin
			new_kind = ndt_pkg::KIND_LOWER;
		end else begin
			new_kind = ndt_pkg::KIND_UNDEF;
		end
	end

	// RAM write and read address selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1[ndt_pkg::EpAddrW-1:0];
		ram_wdata = ram_rdata;
		if (pend_s1) begin
			ram_we = 1'b1;
		end else if (cmd.ins_coord) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = {cfg.join_kind, cfg.coord_ep};
		end else if (cmd.ins_new) begin
			ram_we    = 1'b1;
			ram_waddr = {cnt_idx, {ndt_pkg::EpIdxW{1'b0}}};
			ram_wdata = {cfg.join_kind, epv_q};
		end else if (cmd.ep_write && epw_ok) begin
			ram_we    = 1'b1;
			ram_waddr = {slot_q, eps_q};
			ram_wdata = {epk_q, epv_q};
		end
		if (cmd.ep_rd) begin
			ram_raddr = {fidx_q, j_q[ndt_pkg::EpIdxW-1:0]};
		end else begin
			ram_raddr = rd_q[ndt_pkg::EpAddrW-1:0];
		end
	end

	// status toward the controller
	always_comb begin
		sts.op         = op_q;
		sts.cmd_match  = (cmd_id_q == cfg.join_cmd);
		sts.count_zero = (count_q == '0);
		sts.table_full = (count_q >= CW'(ndt_pkg::MaxDevices));
		sts.idx_end    = (idx_q >= count_q);
		sts.id_match   = (ids_q[idx_q[DW-1:0]] == nid_q);
		sts.ep_end     = (j_q >= epcnt_q[fidx_q]);
		sts.ep_match   = (ram_rdata[ndt_pkg::EpWordW-1:8] == epk_q);
		sts.remove_ok  = epw_ok;
		sts.copy_done  = (rd_q >= end_q) && !pend_s1;
		sts.out_free   = !out_valid_q || m_tready;
	end

	// input capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= s_tdata[2:0];
			cmd_id_q <= s_tdata[10:3];
			nid_q    <= s_tdata[26:11];
			rep_q    <= s_tdata[34:27];
			epv_q    <= s_tdata[42:35];
			epk_q    <= s_tdata[46:43];
			slot_q   <= s_tdata[50:47];
			eps_q    <= s_tdata[53:51];
		end
	end

	// device table entries
	always_ff @(posedge clk) begin
		if (cmd.ins_coord) begin
			ids_q[0]   <= cfg.coord_id;
			kinds_q[0] <= ndt_pkg::KIND_COORD;
			epcnt_q[0] <= ndt_pkg::EpCntW'(1);
		end else if (cmd.ins_new) begin
			ids_q[cnt_idx]   <= nid_q;
			kinds_q[cnt_idx] <= new_kind;
			epcnt_q[cnt_idx] <= ndt_pkg::EpCntW'(1);
		end else if (cmd.ep_write && epw_ok) begin
			if (epcnt_q[slot_q] < ndt_pkg::EpCntW'(ndt_pkg::MaxEndpoints)) begin
				epcnt_q[slot_q] <= epcnt_q[slot_q] + 1'b1;
			end
		end else if (cmd.remove && epw_ok) begin
			for (int i = 0; i < ndt_pkg::MaxDevices - 1; i++) begin
				if ((DW'(i) >= slot_q) && (CW'(i + 1) < count_q)) begin
					ids_q[i]   <= ids_q[i+1];
					kinds_q[i] <= kinds_q[i+1];
					epcnt_q[i] <= epcnt_q[i+1];
				end
			end
		end
	end

	// count and control pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_coord) begin
				count_q <= CW'(1);
			end else if (cmd.ins_new) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.remove && epw_ok) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.copy_step) begin
				pend_s1 <= (rd_q < end_q);
			end else begin
				pend_s1 <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search, copy pointers and result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q   <= '0;
			j_q     <= '0;
			found_q <= 1'b0;
			fidx_q  <= '0;
			fkind_q <= ndt_pkg::KIND_UNDEF;
			fep_q   <= '0;
			rej_q   <= 1'b0;
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.hit) begin
				fidx_q  <= idx_q[DW-1:0];
				fkind_q <= kinds_q[idx_q[DW-1:0]];
				found_q <= (op_q != ndt_pkg::OP_EP_LOOK);
			end
			if (cmd.ins_coord) begin
				fkind_q <= ndt_pkg::KIND_COORD;
			end
			if (cmd.ins_new) begin
				fidx_q  <= cnt_idx;
				fkind_q <= new_kind;
			end
			if (cmd.full_rej || ((cmd.ep_write || cmd.remove) && !epw_ok)) begin
				rej_q <= 1'b1;
			end
			if (cmd.ep_chk) begin
				if (sts.ep_match) begin
					found_q <= 1'b1;
					fep_q   <= ram_rdata[7:0];
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
		// removal: set up the endpoint block copy
		if (cmd.remove) begin
			rd_q  <= PW'({1'b0, slot_q} + 1'b1) << ndt_pkg::EpIdxW;
			end_q <= PW'(count_q) << ndt_pkg::EpIdxW;
		end else if (cmd.copy_step && (rd_q < end_q)) begin
			rd_q <= rd_q + 1'b1;
		end
		if (cmd.copy_step) begin
			wa_s1 <= rd_q - PW'(ndt_pkg::MaxEndpoints);
		end
		if (cmd.out_load) begin
			out_data_q <= {3'b000, count_q, rej_q, fep_q, fkind_q, fidx_q, found_q};
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign dev_count = count_q;

endmodule

[hw/rtl/ndt_ctrl.sv]
// ----------------------------------------------------------------------------
// ndt_ctrl
// Sequencer: dispatch, linear search, endpoint scan, removal copy, output.
// ----------------------------------------------------------------------------
module ndt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ndt_pkg::ndt_sts_t sts,
	output ndt_pkg::ndt_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DISP  = 7'b0000010,
		S_SRCH  = 7'b0000100,
		S_EPRD  = 7'b0001000,
		S_EPCHK = 7'b0010000,
		S_COPY  = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					ndt_pkg::OP_JOIN: begin
						if (!sts.cmd_match) begin
							state_d = S_FIN;
						end else if (sts.count_zero) begin
							cmd.ins_coord = 1'b1;
							state_d       = S_FIN;
						end else begin
							state_d = S_SRCH;
						end
					end
					ndt_pkg::OP_IDX_LOOK, ndt_pkg::OP_TYPE_LOOK, ndt_pkg::OP_EP_LOOK: begin
						state_d = S_SRCH;
					end
					ndt_pkg::OP_EP_WRITE: begin
						cmd.ep_write = 1'b1;
						state_d      = S_FIN;
					end
					ndt_pkg::OP_REMOVE: begin
						cmd.remove = 1'b1;
						state_d    = sts.remove_ok ? S_COPY : S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SRCH: begin
				if (sts.idx_end) begin
					if (sts.op == ndt_pkg::OP_JOIN) begin
						cmd.full_rej = sts.table_full;
						cmd.ins_new  = !sts.table_full;
					end
					state_d = S_FIN;
				end else if (sts.id_match) begin
					cmd.hit = 1'b1;
					state_d = (sts.op == ndt_pkg::OP_EP_LOOK) ? S_EPRD : S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_EPRD: begin
				if (sts.ep_end) begin
					state_d = S_FIN;
				end else begin
					cmd.ep_rd = 1'b1;
					state_d   = S_EPCHK;
				end
			end
			S_EPCHK: begin
				cmd.ep_chk = 1'b1;
				state_d    = sts.ep_match ? S_FIN : S_EPRD;
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/network_device_table.sv]
// ----------------------------------------------------------------------------
// network_device_table
// Table of up to 16 network devices with endpoint lists and six operations.
// ----------------------------------------------------------------------------
// Input stream (s_tvalid/s_tready/s_tdata): one word per operation. Output
// stream (m_tvalid/m_tready/m_tdata): exactly one result word per input word,
// in order. Registers are to be written by the user over the APB port only
// while the block is idle; the block itself does not enforce this. One word
// is worked at a time: it is accepted in the idle state, dispatched, and its
// result is registered in the output register in the finish state. The device
// search scans the entries in order until an ID matches or the count is
// reached; an endpoint lookup reads and checks the endpoints of the found
// device in turn until one matches; a removal copies the endpoint RAM one
// entry per cycle, 8 entries per device above the removed slot. Removing
// slot 0 of a full table takes the longest.
// The next word is taken as soon as the result is loaded in the output
// register, even if the receiver has not taken it yet; a stalled receiver
// holds m_tdata and, once the next result is ready, s_tready stays low.
// Reset empties the table (count zero) and loads the register defaults; the
// endpoint RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module network_device_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[2:0] command_id[10:3] network_id[26:11] report_byte[34:27]
	// endpoint_value[42:35] endpoint_kind[46:43] slot_index[50:47]
	// endpoint_slot[53:51]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0] found_index[4:1] device_kind[6:5] found_endpoint[14:7]
	// rejected[15] device_count[20:16]
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ndt_pkg::ndt_cfg_t cfg_q;
	ndt_pkg::ndt_cmd_t cmd;
	ndt_pkg::ndt_sts_t sts;
	logic [ndt_pkg::CountW-1:0] dev_count;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.join_cmd   <= 8'd0;
			cfg_q.coord_id   <= 16'd0;
			cfg_q.coord_ep   <= 8'd1;
			cfg_q.upper_code <= 8'd1;
			cfg_q.lower_code <= 8'd2;
			cfg_q.join_kind  <= 4'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				ndt_pkg::REG_JOIN_CMD:   cfg_q.join_cmd   <= pwdata[7:0];
				ndt_pkg::REG_COORD_ID:   cfg_q.coord_id   <= pwdata[15:0];
				ndt_pkg::REG_COORD_EP:   cfg_q.coord_ep   <= pwdata[7:0];
				ndt_pkg::REG_UPPER_CODE: cfg_q.upper_code <= pwdata[7:0];
				ndt_pkg::REG_LOWER_CODE: cfg_q.lower_code <= pwdata[7:0];
				ndt_pkg::REG_JOIN_KIND:  cfg_q.join_kind  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[4:2])
			ndt_pkg::REG_JOIN_CMD:   prdata = {24'd0, cfg_q.join_cmd};
			ndt_pkg::REG_COORD_ID:   prdata = {16'd0, cfg_q.coord_id};
			ndt_pkg::REG_COORD_EP:   prdata = {24'd0, cfg_q.coord_ep};
			ndt_pkg::REG_UPPER_CODE: prdata = {24'd0, cfg_q.upper_code};
			ndt_pkg::REG_LOWER_CODE: prdata = {24'd0, cfg_q.lower_code};
			ndt_pkg::REG_JOIN_KIND:  prdata = {28'd0, cfg_q.join_kind};
			default:                 prdata = 32'd0;
		endcase
	end

	ndt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ndt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.dev_count (dev_count)
	);

	// table never holds more than its capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		dev_count <= ndt_pkg::CountW'(ndt_pkg::MaxDevices))
		else $error("device count above capacity");

	// one word at a time: no accept right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a word is in work");

	// a rejected operation never reports a hit
	a_rej_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15]) |-> !m_tdata[0])
		else $error("rejected result with found set");

	// a loaded result always reflects the current count
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (m_tdata[20:16] == dev_count))
		else $error("result count mismatch");

endmodule
